// File: rtl/abcl_pkg.sv
// Shared types, codes and constants for the alarm blink code lock.
package abcl_pkg;

    localparam int CODE_DIGITS = 4;
    localparam logic [3:0] DIGIT_MASK = 4'((32'd1 << CODE_DIGITS) - 32'd1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_TRY  = 2'd1,
        OP_SET  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_THRESHOLD = 3'd0,
        CFG_PERIOD_GAS     = 3'd1,
        CFG_PERIOD_TEMP    = 3'd2,
        CFG_PERIOD_BOTH    = 3'd3,
        CFG_ATTEMPT_LIMIT  = 3'd4
    } t_cfg_idx;

    localparam logic [11:0] RST_TEMP_THRESHOLD = 12'd2048;
    localparam logic [9:0]  RST_PERIOD_GAS     = 10'd100;
    localparam logic [9:0]  RST_PERIOD_TEMP    = 10'd50;
    localparam logic [9:0]  RST_PERIOD_BOTH    = 10'd10;
    localparam logic [3:0]  RST_ATTEMPT_LIMIT  = 4'd5;
    localparam logic [3:0]  RST_STORED_CODE    = 4'd3;

    typedef struct packed {
        logic [11:0] temp_threshold;
        logic [9:0]  period_gas;
        logic [9:0]  period_temp;
        logic [9:0]  period_both;
        logic [3:0]  attempt_limit;
    } t_cfg;

    typedef struct packed {
        t_opcode     opcode;
        logic        gas_detect;
        logic [11:0] temperature_sample;
        logic        enter_button;
        logic [3:0]  code_buttons;
        logic [3:0]  digit_valid;
    } t_in_item;

    typedef struct packed {
        logic       alarm_active;
        logic       alarm_led;
        logic       wrong_code_led;
        logic       blocked_led;
        logic       over_temp_now;
        logic       attempt_ok;
        logic [3:0] failed_attempts;
    } t_out_item;

    typedef struct packed {
        logic       alarm_on;
        logic       gas_latched;
        logic       temp_latched;
        logic       over_temp_flag;
        logic [9:0] blink_ticks;
        logic       alarm_led_level;
        logic       wrong_led_level;
        logic [3:0] failure_count;
        logic       blocked_flag;
        logic [3:0] stored_code;
    } t_state;

    localparam t_state RST_STATE = '{
        alarm_on:        1'b0,
        gas_latched:     1'b0,
        temp_latched:    1'b0,
        over_temp_flag:  1'b0,
        blink_ticks:     10'd0,
        alarm_led_level: 1'b0,
        wrong_led_level: 1'b0,
        failure_count:   4'd0,
        blocked_flag:    1'b0,
        stored_code:     RST_STORED_CODE
    };

endpackage

// File: rtl/abcl_cfg_regs.sv
// Configuration register file: thresholds, blink periods and attempt limit.
module abcl_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [abcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abcl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output abcl_pkg::t_cfg                  o_cfg
);

    abcl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_threshold <= abcl_pkg::RST_TEMP_THRESHOLD;
            r_cfg.period_gas     <= abcl_pkg::RST_PERIOD_GAS;
            r_cfg.period_temp    <= abcl_pkg::RST_PERIOD_TEMP;
            r_cfg.period_both    <= abcl_pkg::RST_PERIOD_BOTH;
            r_cfg.attempt_limit  <= abcl_pkg::RST_ATTEMPT_LIMIT;
        end else if (i_cfg_we) begin
            case (abcl_pkg::t_cfg_idx'(i_cfg_index))
                abcl_pkg::CFG_TEMP_THRESHOLD: r_cfg.temp_threshold <= i_cfg_data[11:0];
                abcl_pkg::CFG_PERIOD_GAS:     r_cfg.period_gas     <= i_cfg_data[9:0];
                abcl_pkg::CFG_PERIOD_TEMP:    r_cfg.period_temp    <= i_cfg_data[9:0];
                abcl_pkg::CFG_PERIOD_BOTH:    r_cfg.period_both    <= i_cfg_data[9:0];
                abcl_pkg::CFG_ATTEMPT_LIMIT:  r_cfg.attempt_limit  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/abcl_engine.sv
// Controller state register and its single-pass next-state and result logic.
module abcl_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  abcl_pkg::t_in_item  i_item,
    input  abcl_pkg::t_cfg      i_cfg,
    output abcl_pkg::t_out_item o_result
);

    abcl_pkg::t_state r_state;
    abcl_pkg::t_state n_state;
    logic             ok;
    logic [9:0]       period;
    logic [3:0]       valid_mask;
    logic [3:0]       buttons_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abcl_pkg::RST_STATE;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign valid_mask = i_item.digit_valid & abcl_pkg::DIGIT_MASK;
    assign buttons_m  = i_item.code_buttons & abcl_pkg::DIGIT_MASK;

    always_comb begin
        n_state = r_state;
        ok      = 1'b0;
        period  = i_cfg.period_temp;
        case (i_item.opcode)
            abcl_pkg::OP_TICK: begin
                // latch sources and alarm
                n_state.over_temp_flag = (i_item.temperature_sample > i_cfg.temp_threshold);
                if (i_item.gas_detect) begin
                    n_state.gas_latched = 1'b1;
                    n_state.alarm_on    = 1'b1;
                end
                if (n_state.over_temp_flag) begin
                    n_state.temp_latched = 1'b1;
                    n_state.alarm_on     = 1'b1;
                end
                // blink counter, saturating
                if (n_state.alarm_on) begin
                    if (!(&r_state.blink_ticks)) begin
                        n_state.blink_ticks = r_state.blink_ticks + 10'd1;
                    end
                    if (n_state.gas_latched && n_state.temp_latched) begin
                        period = i_cfg.period_both;
                    end else if (n_state.gas_latched) begin
                        period = i_cfg.period_gas;
                    end
                    if ((n_state.gas_latched || n_state.temp_latched) &&
                        (n_state.blink_ticks >= period)) begin
                        n_state.blink_ticks     = '0;
                        n_state.alarm_led_level = ~r_state.alarm_led_level;
                    end
                end else begin
                    n_state.alarm_led_level = 1'b0;
                    n_state.gas_latched     = 1'b0;
                    n_state.temp_latched    = 1'b0;
                end
                // panel code entry
                if (r_state.failure_count < i_cfg.attempt_limit) begin
                    if ((buttons_m == abcl_pkg::DIGIT_MASK) && !i_item.enter_button) begin
                        n_state.wrong_led_level = 1'b0;
                    end
                    if (i_item.enter_button && !r_state.wrong_led_level && n_state.alarm_on) begin
                        if (buttons_m == (r_state.stored_code & abcl_pkg::DIGIT_MASK)) begin
                            n_state.alarm_on      = 1'b0;
                            n_state.failure_count = '0;
                            ok                    = 1'b1;
                        end else begin
                            n_state.wrong_led_level = 1'b1;
                            if (!(&r_state.failure_count)) begin
                                n_state.failure_count = r_state.failure_count + 4'd1;
                            end
                        end
                    end
                end else begin
                    n_state.blocked_flag = 1'b1;
                end
            end
            abcl_pkg::OP_TRY: begin
                if (((i_item.code_buttons ^ r_state.stored_code) & valid_mask) == '0) begin
                    n_state.alarm_on        = 1'b0;
                    n_state.wrong_led_level = 1'b0;
                    n_state.failure_count   = '0;
                    ok                      = 1'b1;
                end else begin
                    n_state.wrong_led_level = 1'b1;
                    if (!(&r_state.failure_count)) begin
                        n_state.failure_count = r_state.failure_count + 4'd1;
                    end
                end
            end
            abcl_pkg::OP_SET: begin
                n_state.stored_code = (r_state.stored_code & ~valid_mask) |
                                      (i_item.code_buttons & valid_mask);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.alarm_active    = n_state.alarm_on;
        o_result.alarm_led       = n_state.alarm_led_level;
        o_result.wrong_code_led  = n_state.wrong_led_level;
        o_result.blocked_led     = n_state.blocked_flag;
        o_result.over_temp_now   = n_state.over_temp_flag;
        o_result.attempt_ok      = ok;
        o_result.failed_attempts = n_state.failure_count;
    end

endmodule

// File: rtl/alarm_blink_code_lock_core.sv
// Top level of the alarm blink code lock: input register, engine, result register.
// An item is held in the input register, the engine result is loaded into the
// result register and offered from there.
// Throughput: one item per cycle when i_out_stall is low; the engine updates its
// state in one pass per item. The input register takes items while it is empty
// or the result register drains or is empty.
// Reset (i_rst_n low, synchronous): both stages empty, state and config at defaults.
module alarm_blink_code_lock_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  abcl_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output abcl_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_we,
    input  logic [abcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abcl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    abcl_pkg::t_cfg      cfg;
    abcl_pkg::t_out_item result;
    abcl_pkg::t_in_item  r_in_item;
    abcl_pkg::t_out_item r_out_item;
    logic                r_in_vld;
    logic                r_out_vld;
    logic                advance;
    logic                step;

    // The result stage moves when it is empty or its item is being taken.
    assign advance    = !r_out_vld || !i_out_stall;
    // Hold the input stage only when it is full and cannot move on.
    assign o_in_stall = r_in_vld && !advance;
    // The engine commits one item exactly when it moves into the result stage.
    assign step       = advance && r_in_vld;

    abcl_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    abcl_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input stage: capture a new item whenever it is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    // Result stage: load the engine's result, hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/abcl_checker.sv
// Port-level checker for the alarm blink code lock, bound to the top level.
module abcl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input abcl_pkg::t_out_item o_out_item
);

    logic r_seen_blocked;

    // Remember that a delivered item showed the panel blocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_blocked <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_item.blocked_led) begin
            r_seen_blocked <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.attempt_ok |->
            !o_out_item.alarm_active && !o_out_item.wrong_code_led &&
            (o_out_item.failed_attempts == 4'd0))
        else $error("matching attempt left alarm, wrong led or failures set");

    a_blocked_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_blocked |-> o_out_item.blocked_led)
        else $error("blocked indicator dropped");

endmodule

bind alarm_blink_code_lock_core abcl_checker u_abcl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// File: tb/sv/alarm_blink_code_lock_core_tb.sv
// Self-checking testbench for the alarm blink code lock core.
module alarm_blink_code_lock_core_tb;

    // Clocking, reset and run limits.
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 4;
    // The core holds an item in its input and result registers; allow a margin.
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 8;
    // Longest correct silence comes from a sender gap, a receiver hold and a
    // settings load. Take it several times over.
    localparam int IDLE_LIMIT      = 1000;
    localparam int PRESSURE_AFTER  = 300;
    localparam int PRESSURE_CYCLES = 80;
    localparam int PHASE_ITEMS     = 210;
    localparam int BURST_ITEMS     = 16;
    localparam int PRINT_CAP       = 200;

    // Opcode that the package leaves unnamed; the core must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [3:0] FAIL_MAX  = 4'd15;
    localparam logic [9:0] BLINK_MAX = 10'd1023;

    // Keeps the expected panel/alarm state, predicts the status of every taken
    // item and checks the status items that come out, oldest first.
    class lock_status_board;
        abcl_pkg::t_cfg      cfg;
        abcl_pkg::t_state    st;
        abcl_pkg::t_out_item awaited_status[$];
        int                  errors;
        int                  checked;

        function new();
            cfg.temp_threshold = abcl_pkg::RST_TEMP_THRESHOLD;
            cfg.period_gas     = abcl_pkg::RST_PERIOD_GAS;
            cfg.period_temp    = abcl_pkg::RST_PERIOD_TEMP;
            cfg.period_both    = abcl_pkg::RST_PERIOD_BOTH;
            cfg.attempt_limit  = abcl_pkg::RST_ATTEMPT_LIMIT;
            st                 = '0;
            st.stored_code     = abcl_pkg::RST_STORED_CODE;
            errors             = 0;
            checked            = 0;
        endfunction

        function int pending();
            return awaited_status.size();
        endfunction

        function void bump_failures();
            if (st.failure_count < FAIL_MAX) begin
                st.failure_count = st.failure_count + 4'd1;
            end
        endfunction

        // Advance the lock state by one item and return the status it shows.
        function abcl_pkg::t_out_item advance_lock(abcl_pkg::t_in_item it);
            abcl_pkg::t_out_item res;
            logic                ok;
            logic [9:0]          half;
            logic [3:0]          valid;
            logic [3:0]          btn;
            ok    = 1'b0;
            valid = it.digit_valid & abcl_pkg::DIGIT_MASK;
            btn   = it.code_buttons & abcl_pkg::DIGIT_MASK;
            case (it.opcode)
                abcl_pkg::OP_TICK: begin
                    st.over_temp_flag = (it.temperature_sample > cfg.temp_threshold);
                    if (it.gas_detect) begin
                        st.gas_latched = 1'b1;
                        st.alarm_on    = 1'b1;
                    end
                    if (st.over_temp_flag) begin
                        st.temp_latched = 1'b1;
                        st.alarm_on     = 1'b1;
                    end
                    if (st.alarm_on) begin
                        if (st.blink_ticks < BLINK_MAX) begin
                            st.blink_ticks = st.blink_ticks + 10'd1;
                        end
                        if (st.gas_latched || st.temp_latched) begin
                            if (st.gas_latched && st.temp_latched) begin
                                half = cfg.period_both;
                            end else if (st.gas_latched) begin
                                half = cfg.period_gas;
                            end else begin
                                half = cfg.period_temp;
                            end
                            if (st.blink_ticks >= half) begin
                                st.blink_ticks     = '0;
                                st.alarm_led_level = ~st.alarm_led_level;
                            end
                        end
                    end else begin
                        st.alarm_led_level = 1'b0;
                        st.gas_latched     = 1'b0;
                        st.temp_latched    = 1'b0;
                    end
                    if (st.failure_count < cfg.attempt_limit) begin
                        if (btn == abcl_pkg::DIGIT_MASK && !it.enter_button) begin
                            st.wrong_led_level = 1'b0;
                        end
                        if (it.enter_button && !st.wrong_led_level && st.alarm_on) begin
                            if (btn == (st.stored_code & abcl_pkg::DIGIT_MASK)) begin
                                st.alarm_on      = 1'b0;
                                st.failure_count = '0;
                                ok               = 1'b1;
                            end else begin
                                st.wrong_led_level = 1'b1;
                                bump_failures();
                            end
                        end
                    end else begin
                        st.blocked_flag = 1'b1;
                    end
                end
                abcl_pkg::OP_TRY: begin
                    if (((it.code_buttons ^ st.stored_code) & valid) == 4'd0) begin
                        st.alarm_on        = 1'b0;
                        st.wrong_led_level = 1'b0;
                        st.failure_count   = '0;
                        ok                 = 1'b1;
                    end else begin
                        st.wrong_led_level = 1'b1;
                        bump_failures();
                    end
                end
                abcl_pkg::OP_SET: begin
                    st.stored_code = (st.stored_code & ~valid) | (it.code_buttons & valid);
                end
                default: begin
                end
            endcase
            res.alarm_active    = st.alarm_on;
            res.alarm_led       = st.alarm_led_level;
            res.wrong_code_led  = st.wrong_led_level;
            res.blocked_led     = st.blocked_flag;
            res.over_temp_now   = st.over_temp_flag;
            res.attempt_ok      = ok;
            res.failed_attempts = st.failure_count;
            return res;
        endfunction

        function void note_item(abcl_pkg::t_in_item it);
            awaited_status.push_back(advance_lock(it));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("ERROR status %0d: %s", checked, msg);
            end
        endtask

        task check_status(abcl_pkg::t_out_item got);
            abcl_pkg::t_out_item want;
            if (awaited_status.size() == 0) begin
                report_mismatch("status item with none awaited");
            end else begin
                want = awaited_status.pop_front();
                if (got.alarm_active !== want.alarm_active)
                    report_mismatch($sformatf("alarm_active %b, want %b",
                                              got.alarm_active, want.alarm_active));
                if (got.alarm_led !== want.alarm_led)
                    report_mismatch($sformatf("alarm_led %b, want %b",
                                              got.alarm_led, want.alarm_led));
                if (got.wrong_code_led !== want.wrong_code_led)
                    report_mismatch($sformatf("wrong_code_led %b, want %b",
                                              got.wrong_code_led, want.wrong_code_led));
                if (got.blocked_led !== want.blocked_led)
                    report_mismatch($sformatf("blocked_led %b, want %b",
                                              got.blocked_led, want.blocked_led));
                if (got.over_temp_now !== want.over_temp_now)
                    report_mismatch($sformatf("over_temp_now %b, want %b",
                                              got.over_temp_now, want.over_temp_now));
                if (got.attempt_ok !== want.attempt_ok)
                    report_mismatch($sformatf("attempt_ok %b, want %b",
                                              got.attempt_ok, want.attempt_ok));
                if (got.failed_attempts !== want.failed_attempts)
                    report_mismatch($sformatf("failed_attempts %0d, want %0d",
                                              got.failed_attempts, want.failed_attempts));
            end
            checked++;
        endtask
    endclass

    // Every input holds a known value from time zero.
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    abcl_pkg::t_in_item              i_in_item   = '0;
    logic                            i_out_stall = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [abcl_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [abcl_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    abcl_pkg::t_out_item             o_out_item;

    lock_status_board sb = new();

    // Sender burst: remaining items to send back to back.
    int quiet_sends = 0;

    alarm_blink_code_lock_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic abcl_pkg::t_in_item make_item(logic [1:0] op, logic gas,
                                                     logic [11:0] smp, logic ent,
                                                     logic [3:0] btn, logic [3:0] vld);
        abcl_pkg::t_in_item it;
        it.opcode             = abcl_pkg::t_opcode'(op);
        it.gas_detect         = gas;
        it.temperature_sample = smp;
        it.enter_button       = ent;
        it.code_buttons       = btn;
        it.digit_valid        = vld;
        return it;
    endfunction

    function automatic abcl_pkg::t_cfg make_settings(logic [11:0] thr, logic [9:0] pg,
                                                     logic [9:0] pt, logic [9:0] pb,
                                                     logic [3:0] lim);
        abcl_pkg::t_cfg c;
        c.temp_threshold = thr;
        c.period_gas     = pg;
        c.period_temp    = pt;
        c.period_both    = pb;
        c.attempt_limit  = lim;
        return c;
    endfunction

    // Mostly panel ticks with sensible content: samples around the threshold,
    // enter with the stored code half the time, all buttons held now and then.
    // Remote tries lean toward the stored code so the panel gets unblocked.
    function automatic abcl_pkg::t_in_item random_item();
        abcl_pkg::t_in_item it;
        int                 pick;
        logic [11:0]        thr;
        logic [3:0]         code;
        thr                   = sb.cfg.temp_threshold;
        code                  = sb.st.stored_code;
        it.gas_detect         = 1'($urandom);
        it.temperature_sample = 12'($urandom);
        it.enter_button       = 1'($urandom);
        it.code_buttons       = 4'($urandom);
        it.digit_valid        = 4'($urandom);
        pick                  = $urandom_range(0, 99);
        if (pick < 3) begin
            it.opcode = abcl_pkg::t_opcode'(OP_UNUSED);
        end else if (pick < 15) begin
            it.opcode = abcl_pkg::OP_TRY;
            if ($urandom_range(0, 2) != 0) it.digit_valid = 4'hF;
            if ($urandom_range(0, 4) < 3)
                it.code_buttons = code ^ (4'($urandom) & ~it.digit_valid);
        end else if (pick < 20) begin
            it.opcode = abcl_pkg::OP_SET;
        end else begin
            it.opcode     = abcl_pkg::OP_TICK;
            it.gas_detect = ($urandom_range(0, 24) == 0);
            case ($urandom_range(0, 9))
                0, 1:    it.temperature_sample = 12'($urandom);
                2:       it.temperature_sample = thr;
                3:       it.temperature_sample = (thr == 12'hFFF) ? thr : thr + 12'd1;
                default: it.temperature_sample = 12'($urandom_range(0, thr));
            endcase
            it.enter_button = ($urandom_range(0, 9) < 3);
            if (it.enter_button) begin
                if ($urandom_range(0, 1) == 0) it.code_buttons = code;
            end else if ($urandom_range(0, 4) == 0) begin
                it.code_buttons = 4'hF;
            end
        end
        return it;
    endfunction

    // Offer one item after a random gap, hold it until taken, then note it.
    task automatic send_item(abcl_pkg::t_in_item it);
        int gap;
        int r;
        gap = 0;
        if (quiet_sends > 0) begin
            quiet_sends--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) quiet_sends = $urandom_range(20, 60);
            else if (r < 50) gap = 0;
            else if (r < 88) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
    endtask

    task automatic put_reg(abcl_pkg::t_cfg_idx idx, logic [abcl_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Load all registers once the core has gone quiet.
    task automatic load_settings(abcl_pkg::t_cfg c);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        put_reg(abcl_pkg::CFG_TEMP_THRESHOLD, c.temp_threshold);
        put_reg(abcl_pkg::CFG_PERIOD_GAS, abcl_pkg::CFG_DATA_W'(c.period_gas));
        put_reg(abcl_pkg::CFG_PERIOD_TEMP, abcl_pkg::CFG_DATA_W'(c.period_temp));
        put_reg(abcl_pkg::CFG_PERIOD_BOTH, abcl_pkg::CFG_DATA_W'(c.period_both));
        put_reg(abcl_pkg::CFG_ATTEMPT_LIMIT, abcl_pkg::CFG_DATA_W'(c.attempt_limit));
        i_cfg_we <= 1'b0;
        sb.cfg = c;
    endtask

    // One random phase under new settings; now and then a burst of wrong
    // remote codes drives the failure counter into saturation.
    task automatic run_phase(abcl_pkg::t_cfg c);
        int                 sent;
        int                 k;
        abcl_pkg::t_in_item it;
        load_settings(c);
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) == 0) begin
                for (k = 0; k < BURST_ITEMS; k++) begin
                    it = random_item();
                    it.opcode       = abcl_pkg::OP_TRY;
                    it.digit_valid  = 4'hF;
                    it.code_buttons = ~sb.st.stored_code;
                    send_item(it);
                end
                sent += BURST_ITEMS;
            end else begin
                send_item(random_item());
                sent++;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // Check every status item the core hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_status(o_out_item);
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off that
    // lets the core fill up and push back on the sender.
    initial begin
        int   hold_left;
        int   quiet_left;
        int   r;
        bit   pressure_given;
        logic stall_next;
        hold_left      = 0;
        quiet_left     = 0;
        pressure_given = 1'b0;
        forever begin
            @(posedge i_clk);
            stall_next = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!pressure_given && sb.checked >= PRESSURE_AFTER) begin
                pressure_given = 1'b1;
                hold_left      = PRESSURE_CYCLES - 1;
                stall_next     = 1'b1;
            end else if (quiet_left > 0) begin
                quiet_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    quiet_left = $urandom_range(30, 80);
                end else if (r < 25) begin
                    stall_next = 1'b1;
                    hold_left  = $urandom_range(0, 3);
                end else if (r < 29) begin
                    stall_next = 1'b1;
                    hold_left  = $urandom_range(10, 30);
                end
            end
            i_out_stall <= stall_next;
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset settings: threshold one half, stored code 3.
        send_item(make_item(OP_UNUSED, 1'b1, 12'hFFF, 1'b1, 4'hF, 4'hF)); // ignored op
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b0, 4'h0, 4'h0));
        // equal: no alarm
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd2048, 1'b0, 4'h0, 4'h0));
        // over-temp
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd2049, 1'b0, 4'h0, 4'h0));
        // both sources
        send_item(make_item(abcl_pkg::OP_TICK, 1'b1, 12'd0, 1'b0, 4'h0, 4'h0));
        // wrong code
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b1, 4'hC, 4'h0));
        // locked out by LED
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b1, 4'h3, 4'h0));
        // all held: clear LED
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b0, 4'hF, 4'h0));
        // right code
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b1, 4'h3, 4'h0));
        // LED, latches drop
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b0, 4'h0, 4'h0));
        // no valid digit
        send_item(make_item(abcl_pkg::OP_TRY, 1'b0, 12'd0, 1'b0, 4'h0, 4'h0));
        // remote miss
        send_item(make_item(abcl_pkg::OP_TRY, 1'b0, 12'd0, 1'b0, 4'h0, 4'hF));
        send_item(make_item(abcl_pkg::OP_SET, 1'b0, 12'd0, 1'b0, 4'hA, 4'hF));
        // partial update
        send_item(make_item(abcl_pkg::OP_SET, 1'b0, 12'd0, 1'b0, 4'h5, 4'h1));
        send_item(make_item(abcl_pkg::OP_TRY, 1'b0, 12'd0, 1'b0, 4'hB, 4'hF));
        send_item(make_item(abcl_pkg::OP_TICK, 1'b1, 12'd0, 1'b0, 4'h0, 4'h0));
        // remote clear
        send_item(make_item(abcl_pkg::OP_TRY, 1'b0, 12'd0, 1'b0, 4'hB, 4'hF));
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b0, 4'h0, 4'h0));
        for (k = 0; k < 4; k++) begin
            send_item(make_item(abcl_pkg::OP_TRY, 1'b0, 12'd0, 1'b0, 4'h0, 4'hF));
        end
        send_item(make_item(abcl_pkg::OP_TICK, 1'b1, 12'd0, 1'b0, 4'hF, 4'h0));
        // reach the limit
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b1, 4'h0, 4'h0));
        // panel blocked
        send_item(make_item(abcl_pkg::OP_TICK, 1'b0, 12'd0, 1'b0, 4'h0, 4'h0));
        // unblock count
        send_item(make_item(abcl_pkg::OP_TRY, 1'b0, 12'd0, 1'b0, 4'hB, 4'hF));
        i_in_valid <= 1'b0;

        // Random phases: extremes first, then mid and mixed settings.
        run_phase(make_settings(12'd4095, 10'd1, 10'd1, 10'd1, 4'd15));
        run_phase(make_settings(12'd0, 10'd1023, 10'd1023, 10'd1023, 4'd1));
        run_phase(make_settings(12'($urandom_range(1000, 3000)),
                                10'($urandom_range(2, 12)), 10'($urandom_range(2, 12)),
                                10'($urandom_range(2, 12)), 4'($urandom_range(2, 6))));
        run_phase(make_settings(12'($urandom_range(0, 4095)),
                                10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                                10'($urandom_range(1, 40)), 4'($urandom_range(1, 15))));

        // Drain, then give stray items a chance to show up.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
